// ===== src/natural_log_series_core_assert.svh =====
// Assertion macros shared by the natural log series core.
// Each macro names the assertion, samples on the rising clock edge and is
// disabled while the synchronous reset is asserted.
`ifndef NATURAL_LOG_SERIES_CORE_ASSERT_SVH
`define NATURAL_LOG_SERIES_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LNS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("natural log series core: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LNS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("natural log series core: next-cycle check failed");

`endif

// ===== src/lns_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lns_pkg
// Types and constants shared by the stages of the natural log series core.
// ----------------------------------------------------------------------------
package lns_pkg;

  localparam int SERIES_TERMS = 15;
  localparam int DIV_STEPS    = 30;
  // Input register, divider steps, square, Horner steps, product, output.
  localparam int LATENCY      = 1 + DIV_STEPS + 1 + SERIES_TERMS + 2;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  // Restoring divider stage contents.
  typedef struct packed {
    logic        valid;
    logic        neg;
    logic [32:0] rem;
    logic [32:0] den;
    logic [30:0] quo;
  } div_t;

  // Horner stage contents.
  typedef struct packed {
    logic        valid;
    logic        neg;
    logic [30:0] x_mag;
    logic [30:0] xx;
    logic [31:0] y;
  } hrn_t;

endpackage

// ===== src/lns_div_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lns_div_stage
// One registered step of the restoring divider: one quotient bit per stage.
// ----------------------------------------------------------------------------
module lns_div_stage import lns_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  div_t d_in,
  output div_t d_out
);

  logic [33:0] rem2;
  logic        ge;
  div_t        d_nxt;
  logic        valid_r;
  div_t        pay_r;

  always_comb begin
    rem2        = {d_in.rem, 1'b0};
    ge          = rem2 >= {1'b0, d_in.den};
    d_nxt       = d_in;
    d_nxt.rem   = ge ? 33'(rem2 - {1'b0, d_in.den}) : rem2[32:0];
    d_nxt.quo   = {d_in.quo[29:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= d_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    pay_r <= d_nxt;
  end

  always_comb begin
    d_out       = pay_r;
    d_out.valid = valid_r;
  end

endmodule

// ===== src/lns_horner_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lns_horner_stage
// One registered Horner step: y = recip + ((xx * y) >> 30).
// ----------------------------------------------------------------------------
module lns_horner_stage import lns_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [30:0] recip,
  input  hrn_t        h_in,
  output hrn_t        h_out
);

  logic [62:0] prod;
  logic [32:0] sum;
  hrn_t        h_nxt;
  logic        valid_r;
  hrn_t        pay_r;

  always_comb begin
    prod    = 63'(h_in.xx) * 63'(h_in.y);
    sum     = {2'b00, recip} + prod[62:30];
    h_nxt   = h_in;
    // The series value stays below 4.0, so 32 bits hold it.
    h_nxt.y = sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= h_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    pay_r <= h_nxt;
  end

  always_comb begin
    h_out       = pay_r;
    h_out.valid = valid_r;
  end

endmodule

// ===== src/lns_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lns_out_stage
// Final product 2*x*y, scaling to Q8.24, sign and saturation.
// ----------------------------------------------------------------------------
module lns_out_stage import lns_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  hrn_t        h_in,
  output logic        res_valid,
  output logic [31:0] res_value
);

  logic        p_valid_r;
  logic        p_neg_r;
  logic [62:0] p_prod_r;
  logic [27:0] mag;
  logic [32:0] mag_ext;
  logic [31:0] res_nxt;
  logic        o_valid_r;
  logic [31:0] o_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      p_valid_r <= h_in.valid;
      o_valid_r <= p_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    p_neg_r   <= h_in.neg;
    p_prod_r  <= 63'(h_in.x_mag) * 63'(h_in.y);
    o_value_r <= res_nxt;
  end

  always_comb begin
    mag     = p_prod_r[62:35];
    mag_ext = {5'b0, mag};
    if (p_neg_r) begin
      res_nxt = (mag_ext > 33'h0_8000_0000) ? 32'h8000_0000 : 32'(-mag_ext);
    end else begin
      res_nxt = (mag_ext > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag_ext[31:0];
    end
  end

  assign res_valid = o_valid_r;
  assign res_value = o_value_r;

endmodule

// ===== src/natural_log_series_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// natural_log_series_core
// Pipelined fixed-point natural logarithm by the truncated atanh series.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                         Transfer
//  --------  ----------------------------  ---------------------------------
//  input     start, busy, in_a_value       start high and busy low at clk
//  result    out_valid, out_log_value      out_valid high for one cycle
//
// One argument may be transferred in every cycle. Each result passes through
// one input register, thirty divider steps of one quotient bit each, the
// square, one Horner step per series term, the final product and the output
// register. The thirty-step restoring divider sets the depth of the pipeline.
// Reset is synchronous and active low; it clears the valid bits only, and
// busy is high while reset is held. The receiver cannot stall, so the
// pipeline never stops and busy is otherwise low.
//
module natural_log_series_core import lns_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_a_value,
  output logic        out_valid,
  output logic [31:0] out_log_value
);

`include "natural_log_series_core_assert.svh"

  // Initial series value, the reciprocal of the highest odd term.
  localparam logic [31:0] Y_INIT = 32'((64'd1 << 30) / (2 * SERIES_TERMS + 1));

  logic        accept;
  logic [32:0] den;
  logic        neg;
  logic [31:0] num_mag;
  logic        top_bit;
  div_t        in_nxt;
  logic        in_valid_r;
  div_t        in_pay_r;

  div_t        div_chain [0:DIV_STEPS];
  hrn_t        hrn_chain [0:SERIES_TERMS];

  logic [61:0] sq_prod;
  hrn_t        sq_nxt;
  logic        sq_valid_r;
  hrn_t        sq_pay_r;

  // The pipeline takes an argument whenever it is out of reset.
  assign busy   = !rst_n;
  assign accept = start && !busy;

  // Input stage: numerator magnitude, denominator and the top quotient bit.
  // The magnitude never exceeds the denominator, so the quotient fits in
  // 31 bits and equals 1.0 only for a zero argument.
  always_comb begin
    den     = {1'b0, in_a_value} + {1'b0, ONE_Q16};
    neg     = in_a_value < ONE_Q16;
    num_mag = neg ? (ONE_Q16 - in_a_value) : (in_a_value - ONE_Q16);
    top_bit = {1'b0, num_mag} >= den;
    in_nxt.valid = accept;
    in_nxt.neg   = neg;
    in_nxt.den   = den;
    in_nxt.rem   = top_bit ? 33'({1'b0, num_mag} - den) : {1'b0, num_mag};
    in_nxt.quo   = {30'b0, top_bit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    in_pay_r <= in_nxt;
  end

  always_comb begin
    div_chain[0]       = in_pay_r;
    div_chain[0].valid = in_valid_r;
  end

  // Restoring divider: the remaining thirty quotient bits, one per stage.
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    lns_div_stage u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (div_chain[i]),
      .d_out (div_chain[i + 1])
    );
  end

  // Square stage: xx = (x * x) >> 30 and the series seed.
  always_comb begin
    sq_prod      = 62'(div_chain[DIV_STEPS].quo) * 62'(div_chain[DIV_STEPS].quo);
    sq_nxt.valid = div_chain[DIV_STEPS].valid;
    sq_nxt.neg   = div_chain[DIV_STEPS].neg;
    sq_nxt.x_mag = div_chain[DIV_STEPS].quo;
    sq_nxt.xx    = sq_prod[60:30];
    sq_nxt.y     = Y_INIT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r <= 1'b0;
    end else begin
      sq_valid_r <= sq_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    sq_pay_r <= sq_nxt;
  end

  always_comb begin
    hrn_chain[0]       = sq_pay_r;
    hrn_chain[0].valid = sq_valid_r;
  end

  // Horner steps: the odd divisors run from 2*SERIES_TERMS-1 down to 1.
  for (genvar k = 0; k < SERIES_TERMS; k++) begin : g_hrn
    localparam logic [30:0] RECIP =
      31'((64'd1 << 30) / (2 * (SERIES_TERMS - 1 - k) + 1));
    lns_horner_stage u_hrn (
      .clk   (clk),
      .rst_n (rst_n),
      .recip (RECIP),
      .h_in  (hrn_chain[k]),
      .h_out (hrn_chain[k + 1])
    );
  end

  lns_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .h_in      (hrn_chain[SERIES_TERMS]),
    .res_valid (out_valid),
    .res_value (out_log_value)
  );

  // A transfer reaches the input register in the next cycle.
  `LNS_ASSERT_NEXT(a_in_reg_loaded, accept, in_valid_r)
  // Every result comes from a transfer that passed through the whole pipeline.
  `LNS_ASSERT_SAME(a_out_has_source, out_valid, $past(accept, LATENCY))
  // An argument of exactly 1.0 gives a zero logarithm.
  `LNS_ASSERT_SAME(a_unity_zero, out_valid && ($past(in_a_value, LATENCY) == ONE_Q16),
                   out_log_value == 32'h0000_0000)
  // Arguments above 1.0 never give a negative result.
  `LNS_ASSERT_SAME(a_sign_pos, out_valid && ($past(in_a_value, LATENCY) > ONE_Q16),
                   !out_log_value[31])

endmodule
